// File: rtl/direct_mapped_write_back_cache_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped write-back cache
// Shared property forms for the checker, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_WRITE_BACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITE_BACK_CACHE_ASSERT_SVH

// Same-cycle implication.
`define DMWBC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DMWBC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dmwbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache package
// Default sizes, request codes, sequencer step codes and the microcode table.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

  localparam int INDEX_WIDTH_DEF    = 10;
  localparam int WORDS_PER_LINE_DEF = 4;
  localparam int ADDRESS_WIDTH_DEF  = 16;
  localparam int DATA_W             = 32;

  localparam logic [DATA_W-1:0] UNWRITTEN_MARK = 32'hA000_0000;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam int STEP_W = 3;
  localparam int JMP_W  = 3;

  localparam logic [STEP_W-1:0] ST_CLEAR = 3'd0;
  localparam logic [STEP_W-1:0] ST_IDLE  = 3'd1;
  localparam logic [STEP_W-1:0] ST_LOOK  = 3'd2;
  localparam logic [STEP_W-1:0] ST_WB    = 3'd3;
  localparam logic [STEP_W-1:0] ST_FILL  = 3'd4;
  localparam logic [STEP_W-1:0] ST_FTAIL = 3'd5;
  localparam logic [STEP_W-1:0] ST_ACC   = 3'd6;
  localparam logic [STEP_W-1:0] ST_DONE  = 3'd7;

  localparam logic [JMP_W-1:0] JMP_NEXT      = 3'd0;
  localparam logic [JMP_W-1:0] JMP_GOTO      = 3'd1;
  localparam logic [JMP_W-1:0] JMP_LOOP_BEAT = 3'd2;
  localparam logic [JMP_W-1:0] JMP_LOOP_CLR  = 3'd3;
  localparam logic [JMP_W-1:0] JMP_WAIT_IN   = 3'd4;
  localparam logic [JMP_W-1:0] JMP_WAIT_OUT  = 3'd5;
  localparam logic [JMP_W-1:0] JMP_DISPATCH  = 3'd6;

  typedef struct packed {
    logic              rd_data;
    logic              rd_back;
    logic              push_wb;
    logic              push_fill;
    logic              clr_wr;
    logic              tag_fill;
    logic              acc;
    logic              take;
    logic              give;
    logic [JMP_W-1:0]  jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic hit;
    logic dirty_victim;
  } seq_stat_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      ST_CLEAR: begin
        w.clr_wr = 1'b1;
        w.jump   = JMP_LOOP_CLR;
        w.target = ST_CLEAR;
      end
      ST_IDLE: begin
        w.take = 1'b1;
        w.jump = JMP_WAIT_IN;
      end
      ST_LOOK: begin
        w.jump = JMP_DISPATCH;
      end
      ST_WB: begin
        w.rd_data = 1'b1;
        w.push_wb = 1'b1;
        w.jump    = JMP_LOOP_BEAT;
        w.target  = ST_WB;
      end
      ST_FILL: begin
        w.rd_back   = 1'b1;
        w.push_fill = 1'b1;
        w.jump      = JMP_LOOP_BEAT;
        w.target    = ST_FILL;
      end
      ST_FTAIL: begin
        w.tag_fill = 1'b1;
        w.jump     = JMP_NEXT;
      end
      ST_ACC: begin
        w.acc  = 1'b1;
        w.jump = JMP_NEXT;
      end
      ST_DONE: begin
        w.give   = 1'b1;
        w.jump   = JMP_WAIT_OUT;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/dmwbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache channel interfaces
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface dmwbc_req_if import dmwbc_pkg::*; #(
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [ADDRESS_WIDTH-1:0] address;
  logic [DATA_W-1:0]        write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface dmwbc_rsp_if import dmwbc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  logic              wrote_back;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, hit, wrote_back, read_data, input ready);
  modport sink   (input valid, hit, wrote_back, read_data, output ready);
endinterface

// File: rtl/dmwbc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache microcode sequencer
// Step counter, control word table, word counter and clearing counter.
// ----------------------------------------------------------------------------
module dmwbc_seq import dmwbc_pkg::*; #(
  parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
  parameter int BEAT_W         = 2,
  parameter int CLR_DEPTH      = 16384,
  parameter int CLR_W          = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  seq_stat_t         stat,
  output ucode_t            ctrl,
  output logic [BEAT_W-1:0] beat,
  output logic [CLR_W-1:0]  clr
);

  localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(WORDS_PER_LINE - 1);
  localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(CLR_DEPTH - 1);

  logic [STEP_W-1:0] step_r, step_nxt, step_inc;
  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;
  logic              beat_last, clr_last;

  assign ctrl      = ucode_rom(step_r);
  assign beat      = beat_r;
  assign clr       = clr_r;
  assign step_inc  = step_r + STEP_W'(1);
  assign beat_last = (beat_r == BEAT_LAST);
  assign clr_last  = (clr_r == CLR_LAST);

  always_comb begin
    unique case (ctrl.jump)
      JMP_NEXT:      step_nxt = step_inc;
      JMP_GOTO:      step_nxt = ctrl.target;
      JMP_LOOP_BEAT: step_nxt = beat_last ? step_inc : ctrl.target;
      JMP_LOOP_CLR:  step_nxt = clr_last ? step_inc : ctrl.target;
      JMP_WAIT_IN:   step_nxt = stat.in_valid ? step_inc : step_r;
      JMP_WAIT_OUT:  step_nxt = stat.out_free ? ctrl.target : step_r;
      JMP_DISPATCH: begin
        priority if (stat.hit) begin
          step_nxt = ST_ACC;
        end else if (stat.dirty_victim) begin
          step_nxt = ST_WB;
        end else begin
          step_nxt = ST_FILL;
        end
      end
      default:       step_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    beat_nxt = beat_r;
    if (ctrl.jump == JMP_LOOP_BEAT) begin
      beat_nxt = beat_last ? '0 : beat_r + BEAT_W'(1);
    end
    clr_nxt = clr_r;
    if (ctrl.jump == JMP_LOOP_CLR) begin
      clr_nxt = clr_last ? '0 : clr_r + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLEAR;
      beat_r <= '0;
      clr_r  <= '0;
    end else begin
      step_r <= step_nxt;
      beat_r <= beat_nxt;
      clr_r  <= clr_nxt;
    end
  end

endmodule

// File: rtl/direct_mapped_write_back_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direct-mapped write-back cache
// A hit goes from the lookup to the word access; a clean miss first fills the
// line from the backing store, and a dirty miss first writes the victim line
// back and then fills. Each result word is registered before the next request.
// Requests are taken one at a time; a stalled result word holds the sequencer.
// Reset runs a clearing pass over max(2**INDEX_WIDTH, backing depth) entries
// (16384 by default) before the first request is taken.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache import dmwbc_pkg::*; #(
  parameter int INDEX_WIDTH    = INDEX_WIDTH_DEF,
  parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
  parameter int ADDRESS_WIDTH  = ADDRESS_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  dmwbc_req_if.sink    in_req,
  dmwbc_rsp_if.source  out_rsp
);

  localparam int WORD_BITS   = $clog2(WORDS_PER_LINE);
  localparam int BEAT_W      = (WORD_BITS > 0) ? WORD_BITS : 1;
  localparam int IDX_LSB     = 2 + WORD_BITS;
  localparam int TAG_LSB     = IDX_LSB + INDEX_WIDTH;
  localparam int TAG_RAW     = ADDRESS_WIDTH - TAG_LSB;
  localparam int TAG_W       = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int TE_W        = TAG_W + 2;
  localparam int LINE_COUNT  = 1 << INDEX_WIDTH;
  localparam int BLOCK_W     = ADDRESS_WIDTH - IDX_LSB;
  localparam int NUM_BLOCKS  = 1 << BLOCK_W;
  localparam int BACK_DEPTH  = NUM_BLOCKS * WORDS_PER_LINE;
  localparam int BACK_AW     = $clog2(BACK_DEPTH);
  localparam int DATA_DEPTH  = LINE_COUNT * WORDS_PER_LINE;
  localparam int DATA_AW     = $clog2(DATA_DEPTH);
  localparam int CLR_DEPTH   = (BACK_DEPTH > LINE_COUNT) ? BACK_DEPTH : LINE_COUNT;
  localparam int CLR_W       = $clog2(CLR_DEPTH);

  localparam logic [ADDRESS_WIDTH-1:0] WORD_MASK = ADDRESS_WIDTH'((1 << WORD_BITS) - 1);
  localparam logic [BEAT_W-1:0]        WORD_LAST = BEAT_W'(WORDS_PER_LINE - 1);

  ucode_t            ctrl;
  seq_stat_t         stat;
  logic [BEAT_W-1:0] beat;
  logic [CLR_W-1:0]  clr;

  logic [TE_W-1:0]   tag_mem [LINE_COUNT];
  logic [DATA_W-1:0] data_mem [DATA_DEPTH];
  logic [DATA_W:0]   back_mem [BACK_DEPTH];

  logic [INDEX_WIDTH-1:0] in_idx;
  logic [BEAT_W-1:0]      in_word_raw, in_word;

  logic                   act_r;
  logic [INDEX_WIDTH-1:0] idx_r;
  logic [TAG_W-1:0]       tag_r;
  logic [BEAT_W-1:0]      word_r;
  logic [BLOCK_W-1:0]     blk_r;
  logic [DATA_W-1:0]      wdata_r;

  logic [TE_W-1:0]   tag_rd_r;
  logic [DATA_W-1:0] data_rd_r;
  logic [DATA_W:0]   back_rd_r;

  logic              lag_wb_r, lag_fill_r;
  logic [BEAT_W-1:0] lag_beat_r;

  logic              line_valid, line_dirty, hit, dirty_victim;
  logic [TAG_W-1:0]  line_tag;
  logic [BLOCK_W-1:0] vic_blk;
  logic [DATA_AW-1:0] line_base, data_rd_addr, data_wr_addr;
  logic [BACK_AW-1:0] vic_base, blk_base, back_rd_addr, back_wr_addr, fill_addr;
  logic [DATA_W-1:0]  fill_word, data_wr_word;
  logic               clr_in_lines, clr_in_back, is_write;
  logic               out_free, out_load;

  logic              out_valid_r, out_hit_r, out_wb_r;
  logic [DATA_W-1:0] out_data_r;

  assign in_idx      = INDEX_WIDTH'(in_req.address >> IDX_LSB);
  assign in_word_raw = BEAT_W'((in_req.address >> 2) & WORD_MASK);
  assign in_word     = (in_word_raw > WORD_LAST) ? WORD_LAST : in_word_raw;

  assign line_valid   = tag_rd_r[TE_W-1];
  assign line_dirty   = tag_rd_r[TE_W-2];
  assign line_tag     = tag_rd_r[TAG_W-1:0];
  assign hit          = line_valid && (line_tag == tag_r);
  assign dirty_victim = line_valid && line_dirty;
  assign is_write     = (act_r == ACT_WRITE);

  assign vic_blk   = BLOCK_W'({line_tag, idx_r});
  assign line_base = DATA_AW'(idx_r * WORDS_PER_LINE);
  assign vic_base  = BACK_AW'(vic_blk * WORDS_PER_LINE);
  assign blk_base  = BACK_AW'(blk_r * WORDS_PER_LINE);

  assign data_rd_addr = line_base + DATA_AW'(ctrl.acc ? word_r : beat);
  assign data_wr_addr = line_base + DATA_AW'(lag_fill_r ? lag_beat_r : word_r);
  assign back_rd_addr = blk_base + BACK_AW'(beat);
  assign back_wr_addr = vic_base + BACK_AW'(lag_beat_r);
  assign fill_addr    = blk_base + BACK_AW'(lag_beat_r);
  assign fill_word    = back_rd_r[DATA_W] ? back_rd_r[DATA_W-1:0]
                                          : (UNWRITTEN_MARK | DATA_W'(fill_addr));
  assign data_wr_word = lag_fill_r ? fill_word : wdata_r;

  assign clr_in_lines = ({1'b0, clr} < (CLR_W + 1)'(LINE_COUNT));
  assign clr_in_back  = ({1'b0, clr} < (CLR_W + 1)'(BACK_DEPTH));

  assign out_free = !out_valid_r || out_rsp.ready;
  assign out_load = ctrl.give && out_free;

  assign stat.in_valid     = in_req.valid;
  assign stat.out_free     = out_free;
  assign stat.hit          = hit;
  assign stat.dirty_victim = dirty_victim;

  dmwbc_seq #(
    .WORDS_PER_LINE (WORDS_PER_LINE),
    .BEAT_W         (BEAT_W),
    .CLR_DEPTH      (CLR_DEPTH),
    .CLR_W          (CLR_W)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .beat  (beat),
    .clr   (clr)
  );

  always_ff @(posedge clk) begin
    if (ctrl.take && in_req.valid) begin
      act_r   <= in_req.action;
      idx_r   <= in_idx;
      tag_r   <= TAG_W'(in_req.address >> TAG_LSB);
      word_r  <= in_word;
      blk_r   <= BLOCK_W'(in_req.address >> IDX_LSB);
      wdata_r <= in_req.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      tag_rd_r <= tag_mem[in_idx];
    end
    if (ctrl.clr_wr && clr_in_lines) begin
      tag_mem[clr[INDEX_WIDTH-1:0]] <= '0;
    end else if (ctrl.tag_fill) begin
      tag_mem[idx_r] <= {1'b1, 1'b0, tag_r};
    end else if (ctrl.acc && is_write) begin
      tag_mem[idx_r] <= {1'b1, 1'b1, tag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_data || (ctrl.acc && !is_write)) begin
      data_rd_r <= data_mem[data_rd_addr];
    end
    if (lag_fill_r || (ctrl.acc && is_write)) begin
      data_mem[data_wr_addr] <= data_wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_back) begin
      back_rd_r <= back_mem[back_rd_addr];
    end
    if (ctrl.clr_wr && clr_in_back) begin
      back_mem[clr[BACK_AW-1:0]] <= '0;
    end else if (lag_wb_r) begin
      back_mem[back_wr_addr] <= {1'b1, data_rd_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_wb_r   <= 1'b0;
      lag_fill_r <= 1'b0;
    end else begin
      lag_wb_r   <= ctrl.push_wb;
      lag_fill_r <= ctrl.push_fill;
    end
    lag_beat_r <= beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_hit_r  <= hit;
      out_wb_r   <= !hit && dirty_victim;
      out_data_r <= is_write ? '0 : data_rd_r;
    end
  end

  assign in_req.ready       = ctrl.take;
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.hit        = out_hit_r;
  assign out_rsp.wrote_back = out_wb_r;
  assign out_rsp.read_data  = out_data_r;

endmodule

// File: rtl/dmwbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache port checker
// Watches the request and response ports and is bound to the cache top level.
// ----------------------------------------------------------------------------
`include "direct_mapped_write_back_cache_assert.svh"

module dmwbc_checker import dmwbc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_hit,
  input logic              out_wrote_back,
  input logic [DATA_W-1:0] out_read_data
);

  logic [1:0] pend_r, pend_nxt;

  assign pend_nxt = pend_r + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `DMWBC_ASSERT_IMP(a_no_orphan_word, out_valid, pend_r != 2'd0, "Response word without a request.")
  `DMWBC_ASSERT_IMP(a_two_pending_stall, pend_r == 2'd2, !in_ready, "Third request taken.")
  `DMWBC_ASSERT_IMP(a_wb_only_on_miss, out_valid && out_wrote_back, !out_hit, "Write-back on a hit.")
  `DMWBC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_data) && $stable(out_hit) && $stable(out_wrote_back), "Stalled response word changed.")
  `DMWBC_ASSERT_IMP(a_reset_quiet, $past(!rst_n), !in_ready && !out_valid, "Ports active straight after reset.")

endmodule

bind direct_mapped_write_back_cache dmwbc_checker u_dmwbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_hit        (out_rsp.hit),
  .out_wrote_back (out_rsp.wrote_back),
  .out_read_data  (out_rsp.read_data)
);
